// File: sv/programmable_fsm_reachability_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the programmable FSM reachability core
// Concurrent checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_FSM_REACHABILITY_CORE_ASSERT_SVH
`define PROGRAMMABLE_FSM_REACHABILITY_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define PFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset
`define PFR_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define PFR_ASSERT(lbl, clk, rstn, prop, msg)
`define PFR_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// File: sv/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, codes and constants of the programmable FSM reachability core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfr_pkg;

  // Default machine size and fixed field widths
  localparam int unsigned NumStatesDef = 8;
  localparam int unsigned FieldW       = 3;
  localparam int unsigned MaskW        = 8;
  localparam int unsigned MaxRows      = 8;
  localparam int unsigned RowCntW      = 3;
  localparam int unsigned InitState    = 4;

  // Stream payload widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;

  // Successor table after reset, entry 2*s+b (A=0 .. H=7)
  localparam logic [2:0] InitSucc [16] = '{
    3'd3, 3'd4, 3'd2, 3'd1, 3'd7, 3'd6, 3'd1, 3'd5,
    3'd0, 3'd1, 3'd6, 3'd0, 3'd4, 3'd7, 3'd5, 3'd3
  };

  // Command codes
  typedef enum logic [2:0] {
    OP_ADVANCE    = 3'd0,
    OP_CHANGE     = 3'd1,
    OP_GC_QUERY   = 3'd2,
    OP_GC_DELETE  = 3'd3,
    OP_DELETE_ONE = 3'd4,
    OP_LIST_ROWS  = 3'd5
  } opcode_e;

  // Result payload source
  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_GC,
    OUT_ROW
  } out_kind_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADV_WB,
    ST_EMIT,
    ST_GC_SCAN,
    ST_GC_LO,
    ST_GC_HI,
    ST_GC_DONE,
    ST_LIST_SCAN,
    ST_LIST_LO,
    ST_LIST_HI
  } ctl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      latch_in;
    logic      rd_adv;
    logic      upd_present;
    logic      wr_chg;
    logic      gc_init;
    logic      rd_lo;
    logic      rd_hi;
    logic      mark_exp;
    logic      merge;
    logic      idx_next;
    logic      pass_restart;
    logic      commit_gc;
    logic      list_init;
    logic      cap_zero;
    logic      load_out;
    out_kind_e out_kind;
    logic      out_status;
  } pfr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_e op;
    logic    tgt_ok;
    logic    pending;
    logic    undeleted;
    logic    idx_last;
    logic    changed;
    logic    out_free;
    logic    row_last;
  } pfr_stat_t;

endpackage

// File: sv/pfr_table.sv
// ----------------------------------------------------------------------------
// pfr_table
// Successor memory, one write and one registered read port. Entries not yet
// written read as their reset successor, tracked by one valid bit each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfr_table
  import pfr_pkg::*;
#(
  parameter int unsigned NumStates = NumStatesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [$clog2(NumStates):0]      rd_addr_i,
  output logic [$clog2(NumStates)-1:0]    rd_data_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(NumStates):0]      wr_addr_i,
  input  logic [$clog2(NumStates)-1:0]    wr_data_i
);

  localparam int unsigned SW    = $clog2(NumStates);
  localparam int unsigned AW    = SW + 1;
  localparam int unsigned Depth = 2 * NumStates;

  logic [SW-1:0]    mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [SW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_addr_q;
  logic [SW-1:0]    rst_tbl [Depth];

  // Build reset successors, reduced to the machine size
  for (genvar i = 0; i < Depth; i++) begin : g_rst
    localparam int unsigned RstVal =
      (i < 16) ? (int'(InitSucc[i % 16]) % NumStates) : (i / 2);
    assign rst_tbl[i] = SW'(RstVal);
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Valid bits and read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  // Fall back to the reset successor for entries never written
  assign rd_data_o = rd_vld_q ? rd_data_q : rst_tbl[rd_addr_q];

endmodule

// File: sv/pfr_datapath.sv
// ----------------------------------------------------------------------------
// pfr_datapath
// Current state, deleted mask, reachability walk registers, successor table
// and the result register facing the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "programmable_fsm_reachability_core_assert.svh"

module pfr_datapath
  import pfr_pkg::*;
#(
  parameter int unsigned NumStates = NumStatesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfr_cmd_t            cmd_i,
  output pfr_stat_t           stat_o,
  input  logic [2:0]          opcode_i,
  input  logic                in_bit_i,
  input  logic [FieldW-1:0]   target_state_i,
  input  logic [FieldW-1:0]   pick_state_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  localparam int unsigned NW = NumStates;
  localparam int unsigned SW = $clog2(NumStates);
  localparam int unsigned AW = SW + 1;

  // Latched command fields
  opcode_e           op_q;
  logic              bit_q;
  logic [FieldW-1:0] tgt_q;
  logic [FieldW-1:0] pick_q;

  // Machine and walk state
  logic [SW-1:0]      present_q, present_d;
  logic [NW-1:0]      deleted_q, deleted_d;
  logic [NW-1:0]      reach_q, reach_d;
  logic [NW-1:0]      expanded_q, expanded_d;
  logic               changed_q, changed_d;
  logic [SW-1:0]      idx_q, idx_d;
  logic [RowCntW-1:0] rows_q, rows_d;
  logic [SW-1:0]      row0_q;

  // Result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  // Table port signals
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] tbl_val;
  logic          wr_en;

  // Derived values
  logic          tgt_ok;
  logic          pick_in_range;
  logic          pick_hit;
  logic [NW-1:0] pick_bit;
  logic [NW-1:0] garbage;
  logic [NW-1:0] del_add;
  logic [NW-1:0] gc_mask;
  logic          gc_status;
  logic [NW-1:0] child_bit;
  logic          child_new;
  logic [NW-1:0] live;
  logic [NW-1:0] above;
  logic          row_last;
  logic          out_free;
  logic [OutDataW-1:0] out_word;
  logic          out_last_w;

  // Successor memory
  pfr_table #(
    .NumStates (NumStates)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (tbl_val),
    .wr_en_i   (wr_en),
    .wr_addr_i ({present_q, bit_q}),
    .wr_data_i (SW'(tgt_q))
  );

  // Select table read address
  always_comb begin
    rd_en   = cmd_i.rd_adv | cmd_i.rd_lo | cmd_i.rd_hi;
    rd_addr = {present_q, bit_q};
    if (cmd_i.rd_lo) begin
      rd_addr = {idx_q, 1'b0};
    end else if (cmd_i.rd_hi) begin
      rd_addr = {idx_q, 1'b1};
    end
  end

  assign tgt_ok = int'(tgt_q) < int'(NumStates);
  assign wr_en  = cmd_i.wr_chg & tgt_ok;

  // Garbage and deletion decision
  assign garbage       = ~(deleted_q | reach_q);
  assign pick_in_range = int'(pick_q) < int'(NumStates);
  assign pick_bit      = NW'(1) << SW'(pick_q);
  assign pick_hit      = pick_in_range && ((garbage & pick_bit) != '0);

  always_comb begin
    unique case (op_q)
      OP_DELETE_ONE: begin
        gc_mask   = pick_hit ? pick_bit : '0;
        gc_status = ~pick_hit;
        del_add   = gc_mask;
      end
      OP_GC_DELETE: begin
        gc_mask   = garbage;
        gc_status = (garbage == '0);
        del_add   = garbage;
      end
      default: begin
        gc_mask   = garbage;
        gc_status = (garbage == '0);
        del_add   = '0;
      end
    endcase
  end

  // Child of the walk from the table read
  assign child_bit = NW'(1) << tbl_val;
  assign child_new = ((child_bit & (deleted_q | reach_q)) == '0);

  // Last listed row: no live state above idx, or row limit reached
  assign live     = ~deleted_q;
  assign above    = ~((NW'(2) << idx_q) - NW'(1));
  assign row_last = ((live & above) == '0) || (rows_q == RowCntW'(MaxRows - 1));

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state of machine and walk registers
  always_comb begin
    present_d  = present_q;
    deleted_d  = deleted_q;
    reach_d    = reach_q;
    expanded_d = expanded_q;
    changed_d  = changed_q;
    idx_d      = idx_q;
    rows_d     = rows_q;
    if (cmd_i.upd_present) begin
      present_d = tbl_val;
    end
    if (cmd_i.gc_init) begin
      reach_d    = NW'(1) << present_q;
      expanded_d = '0;
      changed_d  = 1'b0;
      idx_d      = '0;
    end
    if (cmd_i.mark_exp) begin
      expanded_d = expanded_q | (NW'(1) << idx_q);
    end
    if (cmd_i.merge && child_new) begin
      reach_d   = reach_q | child_bit;
      changed_d = 1'b1;
    end
    if (cmd_i.idx_next) begin
      idx_d = idx_q + SW'(1);
    end
    if (cmd_i.pass_restart) begin
      idx_d     = '0;
      changed_d = 1'b0;
    end
    if (cmd_i.commit_gc) begin
      deleted_d = deleted_q | del_add;
    end
    if (cmd_i.list_init) begin
      idx_d  = '0;
      rows_d = '0;
    end
    if (cmd_i.load_out && (cmd_i.out_kind == OUT_ROW)) begin
      rows_d = rows_q + RowCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= SW'(InitState % NumStates);
      deleted_q  <= '0;
      reach_q    <= '0;
      expanded_q <= '0;
      changed_q  <= 1'b0;
      idx_q      <= '0;
      rows_q     <= '0;
    end else begin
      present_q  <= present_d;
      deleted_q  <= deleted_d;
      reach_q    <= reach_d;
      expanded_q <= expanded_d;
      changed_q  <= changed_d;
      idx_q      <= idx_d;
      rows_q     <= rows_d;
    end
  end

  // Capture command fields and zero successor of a listed row
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= opcode_e'(opcode_i);
      bit_q  <= in_bit_i;
      tgt_q  <= target_state_i;
      pick_q <= pick_state_i;
    end
    if (cmd_i.cap_zero) begin
      row0_q <= tbl_val;
    end
  end

  // Assemble result word: r1, r0, row, mask, current, status from the top down
  always_comb begin
    out_word   = '0;
    out_last_w = 1'b1;
    unique case (cmd_i.out_kind)
      OUT_GC: begin
        out_word = {3'b000, 3'b000, 3'b000, 3'b000, MaskW'(gc_mask),
                    FieldW'(present_q), gc_status};
      end
      OUT_ROW: begin
        out_word   = {3'b000, FieldW'(tbl_val), FieldW'(row0_q), FieldW'(idx_q),
                      MaskW'(0), FieldW'(present_q), 1'b0};
        out_last_w = row_last;
      end
      default: begin
        out_word = {3'b000, 3'b000, 3'b000, 3'b000, MaskW'(0),
                    FieldW'(present_q), cmd_i.out_status};
      end
    endcase
  end

  // Result register: load on command, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= out_word;
      out_last_q <= out_last_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // Status to controller
  always_comb begin
    stat_o.op        = op_q;
    stat_o.tgt_ok    = tgt_ok;
    stat_o.pending   = reach_q[idx_q] & ~expanded_q[idx_q];
    stat_o.undeleted = ~deleted_q[idx_q];
    stat_o.idx_last  = (idx_q == SW'(NumStates - 1));
    stat_o.changed   = changed_q;
    stat_o.out_free  = out_free;
    stat_o.row_last  = row_last;
  end

  `PFR_ASSERT(a_expanded_in_reach, clk_i, rst_ni, (expanded_q & ~reach_q) == '0, "expanded state not in reached set")
  `PFR_ASSERT(a_delete_unreached, clk_i, rst_ni, cmd_i.commit_gc |-> ((del_add & reach_q) == '0), "deleting a reachable state")
  `PFR_ASSERT_NEVER(a_load_over_full, clk_i, rst_ni, cmd_i.load_out && !out_free, "result register overwritten")

endmodule

// File: sv/pfr_ctrl.sv
// ----------------------------------------------------------------------------
// pfr_ctrl
// Command sequencer: dispatches each command, steps the reachability walk
// and the row listing, and hands results to the datapath result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pfr_stat_t stat_i,
  output pfr_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_kind = OUT_PLAIN;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (stat_i.op)
          OP_ADVANCE: begin
            cmd_o.rd_adv = 1'b1;
            state_d      = ST_ADV_WB;
          end
          OP_CHANGE: begin
            cmd_o.wr_chg = 1'b1;
            state_d      = ST_EMIT;
          end
          OP_GC_QUERY, OP_GC_DELETE, OP_DELETE_ONE: begin
            cmd_o.gc_init = 1'b1;
            state_d       = ST_GC_SCAN;
          end
          OP_LIST_ROWS: begin
            cmd_o.list_init = 1'b1;
            state_d         = ST_LIST_SCAN;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end

      ST_ADV_WB: begin
        cmd_o.upd_present = 1'b1;
        state_d           = ST_EMIT;
      end

      // Single result of advance, change or an unused code
      ST_EMIT: begin
        unique case (stat_i.op)
          OP_ADVANCE: cmd_o.out_status = 1'b0;
          OP_CHANGE:  cmd_o.out_status = ~stat_i.tgt_ok;
          default:    cmd_o.out_status = 1'b1;
        endcase
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      // Sweep states; expand each reached one not yet expanded
      ST_GC_SCAN: begin
        priority if (stat_i.pending) begin
          cmd_o.rd_lo    = 1'b1;
          cmd_o.mark_exp = 1'b1;
          state_d        = ST_GC_LO;
        end else if (!stat_i.idx_last) begin
          cmd_o.idx_next = 1'b1;
        end else if (stat_i.changed) begin
          cmd_o.pass_restart = 1'b1;
        end else begin
          state_d = ST_GC_DONE;
        end
      end

      ST_GC_LO: begin
        cmd_o.merge = 1'b1;
        cmd_o.rd_hi = 1'b1;
        state_d     = ST_GC_HI;
      end

      ST_GC_HI: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_GC_SCAN;
      end

      // Report and apply deletion in the same cycle
      ST_GC_DONE: begin
        cmd_o.out_kind = OUT_GC;
        if (stat_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.commit_gc = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      ST_LIST_SCAN: begin
        priority if (stat_i.undeleted) begin
          cmd_o.rd_lo = 1'b1;
          state_d     = ST_LIST_LO;
        end else if (!stat_i.idx_last) begin
          cmd_o.idx_next = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_LIST_LO: begin
        cmd_o.cap_zero = 1'b1;
        cmd_o.rd_hi    = 1'b1;
        state_d        = ST_LIST_HI;
      end

      // Hold the row until the result register frees up
      ST_LIST_HI: begin
        cmd_o.out_kind = OUT_ROW;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.row_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_next = 1'b1;
            state_d        = ST_LIST_SCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/programmable_fsm_reachability_core.sv
// ----------------------------------------------------------------------------
// programmable_fsm_reachability_core
// Editable binary-input state machine with a reachability-based collector.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one transfer each; the opcode rides
// in tuser. Results leave on m_axis; tlast marks the final result of a
// command. Every command gives one result except list rows, which gives one
// per undeleted state in ascending order.
// Advance passes through dispatch, table read and emit states; change and
// unused codes through dispatch and emit. Garbage commands walk the successor
// table over its single read port: each pass sweeps all NumStates states and
// reads both successors of each state expanded, and passes repeat until one
// adds no state; a dispatch state comes before the walk and a report state
// after it. Listing takes a dispatch state, then reads both successors of
// each listed row and steps over deleted states.
// One command is in work at a time; the next is taken once the last result
// is loaded, even while that result still waits in the output register.
// A stalled receiver holds the block in place; no result is dropped.
// Reset restores the initial transition table, clears the deleted mask and
// sets the current state to E; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module programmable_fsm_reachability_core
  import pfr_pkg::*;
#(
  parameter int unsigned NumStates = NumStatesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // in_bit, target_state[2:0], pick_state[2:0]
  input  logic [InUserW-1:0]  s_axis_tuser_i,   // opcode[2:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // status, current_state[2:0], state_mask[7:0],
                                                // row_state[2:0], row_next_zero[2:0],
                                                // row_next_one[2:0]
  output logic                m_axis_tlast_o    // last
);

  pfr_cmd_t  cmd;
  pfr_stat_t stat;

  // Sequencer
  pfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, walk registers and result register
  pfr_datapath #(
    .NumStates (NumStates)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (s_axis_tuser_i[2:0]),
    .in_bit_i       (s_axis_tdata_i[0]),
    .target_state_i (s_axis_tdata_i[3:1]),
    .pick_state_i   (s_axis_tdata_i[6:4]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_data_o     (m_axis_tdata_o),
    .out_last_o     (m_axis_tlast_o)
  );

endmodule
